// ===== design/pdde_pkg.sv =====
// Shared constants, codes and handshake types for the PWM duty digit editor.
// No dependencies; imported by every module of the block.
package pdde_pkg;

	localparam int CHANNELS = 24;
	localparam int CH_W     = $clog2(CHANNELS);
	localparam int TON_W    = 10;
	localparam int MODE_W   = 2;
	localparam int SW_W     = 4;

	localparam logic [TON_W-1:0] TON_RESET    = 10'd512;
	localparam logic [TON_W-1:0] TON_THOUSAND = 10'd1000;

	// event codes carried on the input tuser
	localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADJUST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture item, step channel on next-channel events
		logic read;    // registered read of the selected table entry
		logic commit;  // write back and load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;  // result register full and not taken this cycle
	} sts_t;

endpackage

// ===== design/pdde_ctrl.sv =====
// Sequencer for the duty digit editor: accept, read, commit.
// Depends on pdde_pkg for command and status types.
module pdde_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  pdde_pkg::sts_t  sts,
	output pdde_pkg::cmd_t  cmd
);
	import pdde_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_WRIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_WRIT;
			end
			ST_WRIT: begin
				// hold until the result register can take the new result
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.out_busy)
		else $error("commit while result register is blocked");

	a_read_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.read)
		else $error("table read did not follow item capture");

endmodule

// ===== design/pdde_dpath.sv =====
// Datapath of the duty digit editor: channel register, on-time table,
// enable bits, digit adjust logic and result register. Uses pdde_pkg.
module pdde_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pdde_pkg::cmd_t                cmd,
	output pdde_pkg::sts_t                sts,
	input  logic [pdde_pkg::MODE_W-1:0]   mode,
	input  logic [pdde_pkg::SW_W-1:0]     digit_switches,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pdde_pkg::CH_W-1:0]     channel,
	output logic [pdde_pkg::TON_W-1:0]    on_time,
	output logic                          enabled
);
	import pdde_pkg::*;

	// Step one decimal digit. Digits come from constant compares, not dividers.
	function automatic logic [TON_W-1:0] adjust(input logic [TON_W-1:0] v,
	                                            input logic [SW_W-1:0] sw);
		logic        high;
		logic [3:0]  q100;
		logic [3:0]  q10;
		logic [10:0] r100;
		logic [10:0] r10;
		logic [10:0] v11;
		logic [10:0] res;
		logic [3:0]  top;
		v11  = {1'b0, v};
		high = (v >= TON_THOUSAND);
		q100 = '0;
		for (int k = 1; k <= 10; k++) begin
			if (v11 >= 11'(k * 100)) q100 = 4'(k);
		end
		r100 = v11 - 11'(q100) * 11'd100;
		q10  = '0;
		for (int k = 1; k <= 9; k++) begin
			if (r100 >= 11'(k * 10)) q10 = 4'(k);
		end
		r10 = r100 - 11'(q10) * 11'd10;
		res = v11;
		if (sw[3]) begin
			res = high ? 11'd0 : {1'b0, TON_THOUSAND};
		end else if (sw[2]) begin
			if (!high) res = (q100 == 4'd9) ? v11 - 11'd900 : v11 + 11'd100;
		end else if (sw[1]) begin
			top = high ? 4'd2 : 4'd9;
			res = (q10 == top) ? v11 - 11'(top) * 11'd10 : v11 + 11'd10;
		end else if (sw[0]) begin
			top = high ? 4'd3 : 4'd9;
			res = (r10 == 11'(top)) ? v11 - 11'(top) : v11 + 11'd1;
		end
		return res[TON_W-1:0];
	endfunction

	logic [TON_W-1:0]  ton_mem [CHANNELS];
	logic [CHANNELS-1:0] ton_vld_q;
	logic [CHANNELS-1:0] en_q;
	logic [CH_W-1:0]   chan_q;
	logic [MODE_W-1:0] mode_q;
	logic [SW_W-1:0]   sw_q;
	logic [TON_W-1:0]  rd_q;
	logic              rd_vld_q;
	logic [TON_W-1:0]  ton_cur;
	logic [TON_W-1:0]  ton_new;
	logic              out_vld_q;
	logic [CH_W-1:0]   out_chan_q;
	logic [TON_W-1:0]  out_ton_q;
	logic              out_en_q;

	// entries never written read as the reset on-time
	assign ton_cur = rd_vld_q ? rd_q : TON_RESET;
	assign ton_new = (mode_q == MODE_ADJUST) ? adjust(ton_cur, sw_q) : ton_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q    <= '0;
			ton_vld_q <= '0;
			en_q      <= '0;
			rd_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.load && mode == MODE_NEXT) begin
				chan_q <= (chan_q >= CH_W'(CHANNELS - 1)) ? '0 : chan_q + 1'b1;
			end
			if (cmd.read) begin
				rd_vld_q <= ton_vld_q[chan_q];
			end
			if (cmd.commit) begin
				if (mode_q == MODE_ADJUST) ton_vld_q[chan_q] <= 1'b1;
				if (mode_q == MODE_TOGGLE) en_q[chan_q] <= ~en_q[chan_q];
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			sw_q   <= digit_switches;
		end
		if (cmd.read) begin
			rd_q <= ton_mem[chan_q];
		end
		if (cmd.commit) begin
			if (mode_q == MODE_ADJUST) ton_mem[chan_q] <= ton_new;
			out_chan_q <= chan_q;
			out_ton_q  <= ton_new;
			out_en_q   <= en_q[chan_q] ^ (mode_q == MODE_TOGGLE);
		end
	end

	assign sts.out_busy = out_vld_q && !out_ready;
	assign out_valid    = out_vld_q;
	assign channel      = out_chan_q;
	assign on_time      = out_ton_q;
	assign enabled      = out_en_q;

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q <= CH_W'(CHANNELS - 1))
		else $error("selected channel out of range");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(cmd.commit))
		else $error("result appeared without a commit");

endmodule

// ===== design/pwm_duty_digit_editor_core.sv =====
// Top level of the PWM duty digit editor: stream ports around the
// sequencer (pdde_ctrl) and the datapath (pdde_dpath). Uses pdde_pkg.
//
// Each input item is one front-panel event and yields exactly one result item
// with the selected channel, its on-time (0..1023) and its enable bit after the
// event. The event code travels on s_tuser: 0 selects the next channel (the
// last channel wraps to 0), 1 steps the decimal digit picked by the highest set
// switch in s_tdata (thousands toggles 0/1000; at 1000 and above hundreds is
// frozen, tens wraps after 2 and units after 3), 2 flips the channel's enable
// bit, and 3 changes nothing. After reset channel 0 is selected, every on-time
// is 512 and every channel is disabled; no clearing pass is needed, so items
// are taken from the first cycle. An item passes through capture, a registered
// table read and write-back into the result register; its result is offered
// on m_tvalid once the write-back has loaded the result register, and no new
// item is accepted until that write-back is done. The result register frees
// the input side: the next item is accepted while a result still waits, and
// only the write-back of that next item holds until m_tready takes the earlier
// result.
module pwm_duty_digit_editor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] digit_switches, [7:4] zero
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [4:0] channel, [14:5] on_time, [15] enabled
);
	import pdde_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [CH_W-1:0]   channel;
	logic [TON_W-1:0]  on_time;
	logic              enabled;

	pdde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// unused high bits of s_tdata are ignored
	pdde_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (s_tuser[MODE_W-1:0]),
		.digit_switches (s_tdata[SW_W-1:0]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.channel        (channel),
		.on_time        (on_time),
		.enabled        (enabled)
	);

	// pack the result; channel fills its five-bit field
	assign m_tdata = {enabled, on_time, 5'(channel)};

endmodule
